// ===== design/tbp_pkg.sv =====
`default_nettype none
package tbp_pkg;

   localparam int BASE_INDEX_BITS_DEF   = 12;
   localparam int TAGGED_INDEX_BITS_DEF = 10;
   localparam int TAG_BITS_DEF          = 8;

   localparam int NUM_BANKS  = 4;
   localparam int CTR_BITS   = 3;
   localparam int USE_BITS   = 2;
   localparam int PERIOD_W   = 25;
   localparam int COUNT_W    = 24;
   localparam int HIST_LO_W  = 64;
   localparam int HIST_HI_W  = 17;
   localparam int WFOLD_W    = 8;
   localparam int NFOLD_W    = 7;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 25'd262144;
   localparam logic [PERIOD_W-1:0] PERIOD_CAP   = 25'd16777216;

   localparam logic signed [CTR_BITS-1:0] CTR_MAX       = 3'sd3;
   localparam logic signed [CTR_BITS-1:0] CTR_MIN       = -3'sd4;
   localparam logic signed [CTR_BITS-1:0] CTR_WEAK_TAKE = 3'sd0;
   localparam logic signed [CTR_BITS-1:0] CTR_WEAK_NOT  = -3'sd1;
   localparam logic [USE_BITS-1:0]        USE_MAX       = 2'd3;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_TRAIN   = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_AGE
   } state_type;

   typedef struct packed {
      logic       prediction;
      logic [2:0] provider_bank;
   } lookup_type;

endpackage
`default_nettype wire

// ===== design/tage_branch_predictor_top.sv =====
`default_nettype none
// TAGE direction predictor: base table plus four tagged banks (history 10/20/40/80).
// Request: start with req_op/req_pc/req_outcome/req_random_pick is taken when busy
// is low. req_op 0 only predicts; req_op 1 also trains with req_outcome.
// Response: rsp_valid pulses for one cycle with rsp_prediction (direction before
// any update) and rsp_provider_bank. rsp_valid is registered from the LOOKUP state that
// the accepting edge enters. The receiver cannot stall; every response is a single pulse.
// A new item is taken only from idle, never while the last is in LOOKUP, set by the read then write-back of the
// single-port-read table RAMs (read at accept, modify and write in the next cycle).
// Useful-bit aging: when a train item closes an aging period, busy stays high
// while the useful fields of every tagged entry are masked in a read/write sweep.
// CSR: csr_valid with csr_aging_period writes the aging period; csr_ready is always
// high. Write it only while the block is idle.
// Reset: synchronous, active high. Afterwards the tables are zeroed by a sweep over
// 2^max(BASE_INDEX_BITS, TAGGED_INDEX_BITS) addresses (4096 by default) with busy high.
module tage_branch_predictor_top #(
   parameter int BASE_INDEX_BITS   = tbp_pkg::BASE_INDEX_BITS_DEF,
   parameter int TAGGED_INDEX_BITS = tbp_pkg::TAGGED_INDEX_BITS_DEF,
   parameter int TAG_BITS          = tbp_pkg::TAG_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_op,
   input  wire logic [31:0]                    req_pc,
   input  wire logic                           req_outcome,
   input  wire logic [1:0]                     req_random_pick,
   output logic                                rsp_valid,
   output logic                                rsp_prediction,
   output logic      [2:0]                     rsp_provider_bank,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tbp_pkg::PERIOD_W-1:0]   csr_aging_period
);
   import tbp_pkg::*;

   localparam int BIB   = BASE_INDEX_BITS;
   localparam int TIB   = TAGGED_INDEX_BITS;
   localparam int EW    = TAG_BITS + 5;
   localparam int CW    = (BIB > TIB) ? BIB : TIB;
   localparam int TSIZE = 1 << TIB;

   state_type state_ff, state_in;

   logic                               accept;
   logic [NUM_BANKS-1:0][TIB-1:0]      idx_c, idx_ff;
   logic [NUM_BANKS-1:0][TAG_BITS-1:0] tag_c, tag_ff;
   logic [BIB-1:0]                     bidx_ff;
   logic                               op_ff, outcome_ff;
   logic [1:0]                         pick_ff;
   logic                               train;

   logic [CTR_BITS-1:0]                base_rd, base_wr, base_wdata;
   logic [BIB-1:0]                     base_waddr, base_raddr;
   logic                               base_we;
   logic [NUM_BANKS-1:0][EW-1:0]       bank_rd, bank_wr, bank_wdata;
   logic [NUM_BANKS-1:0][TIB-1:0]      bank_waddr, bank_raddr;
   logic                               bank_we;
   lookup_type                         res;

   logic [CW-1:0]                      clr_ff, clr_in;
   logic [TIB:0]                       sw_ff, sw_in;
   logic [TIB:0]                       sw_prev;
   logic [USE_BITS-1:0]                mask_ff, mask_in;

   logic [PERIOD_W-1:0]                period_ff, period_eff, count_next;
   logic [COUNT_W-1:0]                 count_ff, count_in;
   logic                               clear_high_ff, clear_high_in;
   logic                               age;

   logic                               rsp_valid_ff;
   logic                               rsp_pred_ff;
   logic [2:0]                         rsp_prov_ff;

   tbp_hist #(
      .TAGGED_INDEX_BITS (TIB),
      .TAG_BITS          (TAG_BITS)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .shift_en (train),
      .taken    (outcome_ff),
      .pc       (req_pc),
      .idx      (idx_c),
      .tag      (tag_c)
   );

   tbp_update #(
      .TAG_BITS (TAG_BITS)
   ) u_update (
      .base_rd (base_rd),
      .bank_rd (bank_rd),
      .tag     (tag_ff),
      .outcome (outcome_ff),
      .pick    (pick_ff),
      .res     (res),
      .base_wr (base_wr),
      .bank_wr (bank_wr)
   );

   tbp_ram #(
      .WIDTH (CTR_BITS),
      .DEPTH (1 << BIB)
   ) u_base_ram (
      .clock (clock),
      .we    (base_we),
      .waddr (base_waddr),
      .wdata (base_wdata),
      .raddr (base_raddr),
      .rdata (base_rd)
   );

   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
      tbp_ram #(
         .WIDTH (EW),
         .DEPTH (TSIZE)
      ) u_bank_ram (
         .clock (clock),
         .we    (bank_we),
         .waddr (bank_waddr[g]),
         .wdata (bank_wdata[g]),
         .raddr (bank_raddr[g]),
         .rdata (bank_rd[g])
      );
   end

   // aging period bookkeeping
   always_comb begin
      if (period_ff == '0) begin
         period_eff = PERIOD_W'(1);
      end else if (period_ff > PERIOD_CAP) begin
         period_eff = PERIOD_CAP;
      end else begin
         period_eff = period_ff;
      end
      age        = train && ({1'b0, count_ff} == period_eff - PERIOD_W'(1));
      count_next = {1'b0, count_ff} + PERIOD_W'(1);
      if (count_next >= period_eff) begin
         count_next = '0;
      end
      count_in      = train ? count_next[COUNT_W-1:0] : count_ff;
      clear_high_in = age ? !clear_high_ff : clear_high_ff;
      mask_in       = age ? (clear_high_ff ? 2'b01 : 2'b10) : mask_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE:   if (start) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = age ? ST_AGE : ST_IDLE;
         ST_AGE:    if (sw_ff == (TIB+1)'(TSIZE)) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      busy       = 1'b1;
      accept     = 1'b0;
      train      = 1'b0;
      base_we    = 1'b0;
      bank_we    = 1'b0;
      base_waddr = bidx_ff;
      base_wdata = base_wr;
      base_raddr = req_pc[BIB-1:0];
      bank_waddr = idx_ff;
      bank_wdata = bank_wr;
      bank_raddr = idx_c;
      clr_in     = clr_ff;
      sw_in      = sw_ff;
      sw_prev    = sw_ff - (TIB+1)'(1);
      case (state_ff)
         ST_CLEAR: begin
            base_we    = 1'b1;
            bank_we    = 1'b1;
            base_waddr = clr_ff[BIB-1:0];
            base_wdata = '0;
            for (int b = 0; b < NUM_BANKS; b++) begin
               bank_waddr[b] = clr_ff[TIB-1:0];
               bank_wdata[b] = '0;
            end
            clr_in = clr_ff + CW'(1);
         end
         ST_IDLE: begin
            busy   = 1'b0;
            accept = start;
         end
         ST_LOOKUP: begin
            train   = (op_ff == OP_TRAIN);
            base_we = train;
            bank_we = train;
            sw_in   = '0;
         end
         ST_AGE: begin
            // read one entry ahead of the write-back
            bank_we = (sw_ff != '0);
            for (int b = 0; b < NUM_BANKS; b++) begin
               bank_raddr[b] = sw_ff[TIB-1:0];
               bank_waddr[b] = sw_prev[TIB-1:0];
               bank_wdata[b] = bank_rd[b];
               bank_wdata[b][TAG_BITS+1:TAG_BITS] = bank_rd[b][TAG_BITS+1:TAG_BITS] & mask_ff;
            end
            sw_in = sw_ff + (TIB+1)'(1);
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         sw_ff         <= '0;
         period_ff     <= PERIOD_RESET;
         count_ff      <= '0;
         clear_high_ff <= 1'b1;
         mask_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         sw_ff         <= sw_in;
         count_ff      <= count_in;
         clear_high_ff <= clear_high_in;
         mask_ff       <= mask_in;
         rsp_valid_ff  <= (state_ff == ST_LOOKUP);
         if (csr_valid && csr_ready) begin
            period_ff <= csr_aging_period;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff     <= idx_c;
         tag_ff     <= tag_c;
         bidx_ff    <= req_pc[BIB-1:0];
         op_ff      <= req_op;
         outcome_ff <= req_outcome;
         pick_ff    <= req_random_pick;
      end
      if (state_ff == ST_LOOKUP) begin
         rsp_pred_ff <= res.prediction;
         rsp_prov_ff <= res.provider_bank;
      end
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_prediction    = rsp_pred_ff;
   assign rsp_provider_bank = rsp_prov_ff;

endmodule
`default_nettype wire

// ===== design/tbp_ram.sv =====
`default_nettype none
module tbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== design/tbp_hist.sv =====
`default_nettype none
module tbp_hist #(
   parameter int TAGGED_INDEX_BITS = tbp_pkg::TAGGED_INDEX_BITS_DEF,
   parameter int TAG_BITS          = tbp_pkg::TAG_BITS_DEF
) (
   input  wire logic                                               clock,
   input  wire logic                                               reset,
   input  wire logic                                               shift_en,
   input  wire logic                                               taken,
   input  wire logic [31:0]                                        pc,
   output logic [tbp_pkg::NUM_BANKS-1:0][TAGGED_INDEX_BITS-1:0]    idx,
   output logic [tbp_pkg::NUM_BANKS-1:0][TAG_BITS-1:0]             tag
);
   import tbp_pkg::*;

   localparam int TIB = TAGGED_INDEX_BITS;

   logic [HIST_LO_W-1:0]                 hlow_ff,  hlow_in;
   logic [HIST_HI_W-1:0]                 hhigh_ff, hhigh_in;
   logic [NUM_BANKS-2:0][TIB-1:0]        ifold_ff, ifold_in;
   logic [NUM_BANKS-1:0][WFOLD_W-1:0]    wfold_ff, wfold_in;
   logic [NUM_BANKS-1:0][NFOLD_W-1:0]    nfold_ff, nfold_in;
   logic [NUM_BANKS-1:0]                 hl;
   logic [TIB-1:0]                       pcmix;
   logic [31:0]                          tmix [NUM_BANKS];

   // lookup side
   always_comb begin
      pcmix  = pc[TIB-1:0] ^ pc[2*TIB-1:TIB];
      idx[0] = pcmix ^ hlow_ff[TIB-1:0];
      for (int b = 1; b < NUM_BANKS; b++) begin
         idx[b] = pcmix ^ ifold_ff[b-1];
      end
      for (int b = 0; b < NUM_BANKS; b++) begin
         tmix[b] = pc ^ {24'b0, wfold_ff[b]} ^ {24'b0, nfold_ff[b], 1'b0};
         tag[b]  = tmix[b][TAG_BITS-1:0];
      end
   end

   // history shift; hl holds the new history's bits 10, 20, 40 and 80
   always_comb begin
      hlow_in  = {hlow_ff[HIST_LO_W-2:0], taken};
      hhigh_in = {hhigh_ff[HIST_HI_W-2:0], hlow_ff[HIST_LO_W-1]};
      hl[0] = hlow_ff[9];
      hl[1] = hlow_ff[19];
      hl[2] = hlow_ff[39];
      hl[3] = hhigh_ff[15];
      for (int b = 0; b < NUM_BANKS-1; b++) begin
         ifold_in[b] = {ifold_ff[b][TIB-2:0], taken ^ hl[b+1] ^ ifold_ff[b][TIB-1]};
      end
      for (int b = 0; b < NUM_BANKS; b++) begin
         wfold_in[b]    = {wfold_ff[b][6:0], taken ^ wfold_ff[b][7]};
         wfold_in[b][4] = hl[b] ^ wfold_ff[b][3];
         nfold_in[b]    = {nfold_ff[b][5:0], taken ^ nfold_ff[b][6]};
         nfold_in[b][4] = hl[b] ^ nfold_ff[b][3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hlow_ff  <= '0;
         hhigh_ff <= '0;
         ifold_ff <= '0;
         wfold_ff <= '0;
         nfold_ff <= '0;
      end else if (shift_en) begin
         hlow_ff  <= hlow_in;
         hhigh_ff <= hhigh_in;
         ifold_ff <= ifold_in;
         wfold_ff <= wfold_in;
         nfold_ff <= nfold_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/tbp_update.sv =====
`default_nettype none
module tbp_update #(
   parameter int TAG_BITS = tbp_pkg::TAG_BITS_DEF
) (
   input  wire logic [tbp_pkg::CTR_BITS-1:0]                        base_rd,
   input  wire logic [tbp_pkg::NUM_BANKS-1:0][TAG_BITS+4:0]         bank_rd,
   input  wire logic [tbp_pkg::NUM_BANKS-1:0][TAG_BITS-1:0]         tag,
   input  wire logic                                                outcome,
   input  wire logic [1:0]                                          pick,
   output tbp_pkg::lookup_type                                      res,
   output logic      [tbp_pkg::CTR_BITS-1:0]                        base_wr,
   output logic      [tbp_pkg::NUM_BANKS-1:0][TAG_BITS+4:0]         bank_wr
);
   import tbp_pkg::*;

   // entry: {ctr, useful, tag}
   localparam int EW = TAG_BITS + 5;

   logic signed [CTR_BITS-1:0] ctr  [NUM_BANKS];
   logic signed [CTR_BITS-1:0] nctr [NUM_BANKS];
   logic [USE_BITS-1:0]        u    [NUM_BANKS];
   logic [USE_BITS-1:0]        nu   [NUM_BANKS];
   logic [TAG_BITS-1:0]        ntag [NUM_BANKS];
   logic signed [CTR_BITS-1:0] bctr, nbctr, pctr, actr;
   logic [2:0]                 prov, alt;
   logic                       pred, altpred, move_alt, pmove, amove, mispred;
   logic                       has_first, has_second;
   logic [1:0]                 first, second, pickb;
   logic [USE_BITS-1:0]        pu;

   always_comb begin
      bctr = base_rd;
      prov = 3'd0;
      alt  = 3'd0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         ctr[b]  = bank_rd[b][EW-1 -: CTR_BITS];
         u[b]    = bank_rd[b][TAG_BITS+1:TAG_BITS];
         nctr[b] = ctr[b];
         nu[b]   = u[b];
         ntag[b] = bank_rd[b][TAG_BITS-1:0];
         if (bank_rd[b][TAG_BITS-1:0] == tag[b]) begin
            alt  = prov;
            prov = 3'(b + 1);
         end
      end
      nbctr = bctr;

      pctr = bctr;
      actr = bctr;
      pu   = '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         if (prov == 3'(b + 1)) begin
            pctr = ctr[b];
            pu   = u[b];
         end
         if (alt == 3'(b + 1)) begin
            actr = ctr[b];
         end
      end
      pred    = (pctr >= 0);
      altpred = (actr >= 0);
      res.prediction    = pred;
      res.provider_bank = prov;

      // counter update of provider and, when it is not yet useful, alternate
      move_alt = (prov != 3'd0) && (pu == '0);
      pmove    = outcome ? (pctr != CTR_MAX) : (pctr != CTR_MIN);
      amove    = pmove && move_alt && (outcome ? (actr != CTR_MAX) : (actr != CTR_MIN));
      if (pmove) begin
         if (prov == 3'd0) begin
            nbctr = outcome ? bctr + 3'sd1 : bctr - 3'sd1;
         end
         for (int b = 0; b < NUM_BANKS; b++) begin
            if (prov == 3'(b + 1)) begin
               nctr[b] = outcome ? ctr[b] + 3'sd1 : ctr[b] - 3'sd1;
            end
         end
      end
      if (amove) begin
         if (alt == 3'd0) begin
            nbctr = outcome ? bctr + 3'sd1 : bctr - 3'sd1;
         end
         for (int b = 0; b < NUM_BANKS; b++) begin
            if (alt == 3'(b + 1)) begin
               nctr[b] = outcome ? ctr[b] + 3'sd1 : ctr[b] - 3'sd1;
            end
         end
      end

      // allocation above the provider on a miss
      mispred    = (pred != outcome) && (prov < 3'(NUM_BANKS));
      has_first  = 1'b0;
      has_second = 1'b0;
      first      = '0;
      second     = '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         if ((3'(b) >= prov) && (u[b] == '0)) begin
            if (!has_first) begin
               has_first = 1'b1;
               first     = 2'(b);
            end else if (!has_second) begin
               has_second = 1'b1;
               second     = 2'(b);
            end
         end
      end
      pickb = (has_second && pick >= 2'd2) ? second : first;
      if (mispred) begin
         for (int b = 0; b < NUM_BANKS; b++) begin
            if (!has_first) begin
               if ((3'(b) >= prov) && (u[b] != '0)) begin
                  nu[b] = u[b] - 2'd1;
               end
            end else if (pickb == 2'(b)) begin
               ntag[b] = tag[b];
               nctr[b] = outcome ? CTR_WEAK_TAKE : CTR_WEAK_NOT;
               nu[b]   = '0;
            end
         end
      end

      // usefulness duel between provider and alternate
      if ((prov != 3'd0) && (altpred != pred)) begin
         for (int b = 0; b < NUM_BANKS; b++) begin
            if (prov == 3'(b + 1)) begin
               if (pred == outcome) begin
                  if (u[b] != USE_MAX) nu[b] = u[b] + 2'd1;
               end else begin
                  if (u[b] != '0) nu[b] = u[b] - 2'd1;
               end
            end
         end
      end

      base_wr = nbctr;
      for (int b = 0; b < NUM_BANKS; b++) begin
         bank_wr[b] = {nctr[b], nu[b], ntag[b]};
      end
   end

endmodule
`default_nettype wire

// ===== verif/tb_tage_branch_predictor_top.sv =====
`default_nettype none
module tb_tage_branch_predictor_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tbp_pkg::*;

   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  DRAIN_CYCLES = 1100;
   localparam int  POOL_SIZE = 32;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_op = OP_PREDICT;
   logic [31:0]         req_pc = '0;
   logic                req_outcome = 1'b0;
   logic [1:0]          req_random_pick = '0;
   logic                rsp_valid;
   logic                rsp_prediction;
   logic [2:0]          rsp_provider_bank;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [PERIOD_W-1:0] csr_aging_period = PERIOD_RESET;

   tage_branch_predictor_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_pc(req_pc), .req_outcome(req_outcome),
      .req_random_pick(req_random_pick),
      .rsp_valid(rsp_valid), .rsp_prediction(rsp_prediction),
      .rsp_provider_bank(rsp_provider_bank),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_aging_period(csr_aging_period)
   );

   always #10 clock = ~clock;

   // predictor state
   logic signed [CTR_BITS-1:0] base_ctr [4096];
   logic signed [CTR_BITS-1:0] bank_ctr [NUM_BANKS][1024];
   logic [7:0]                 bank_tag [NUM_BANKS][1024];
   logic [USE_BITS-1:0]        bank_use [NUM_BANKS][1024];
   logic [HIST_LO_W-1:0]       hist_lo;
   logic [HIST_HI_W-1:0]       hist_hi;
   logic [9:0]                 idx_fold [3];
   logic [WFOLD_W-1:0]         wide_fold [NUM_BANKS];
   logic [NFOLD_W-1:0]         narrow_fold [NUM_BANKS];
   logic [COUNT_W-1:0]         train_cnt;
   logic                       clear_high;
   logic [PERIOD_W-1:0]        aging_period;
   logic [9:0]                 cur_idx [NUM_BANKS];
   logic [11:0]                cur_base;

   lookup_type pending_lookups [$];
   int errors = 0;
   int cycles = 0;
   int items_sent = 0;
   int trains_sent = 0;
   int agings_seen = 0;
   int burst_left = 0;
   logic [31:0] pc_pool [POOL_SIZE];
   logic [7:0]  outcome_hist = '0;

   function automatic logic signed [CTR_BITS-1:0] ctr_get(input int bank);
      if (bank == 0) return base_ctr[cur_base];
      return bank_ctr[bank-1][cur_idx[bank-1]];
   endfunction

   function automatic void ctr_set(input int bank, input logic signed [CTR_BITS-1:0] v);
      if (bank == 0) base_ctr[cur_base] = v;
      else bank_ctr[bank-1][cur_idx[bank-1]] = v;
   endfunction

   function automatic void tage_step(input logic op, input logic [31:0] pc, input logic taken,
                                     input logic [1:0] pick, output lookup_type res);
      logic [9:0] pcmix;
      logic [7:0] tg [NUM_BANKS];
      int pv, al, first, second, pk, b, i;
      logic signed [CTR_BITS-1:0] p_ctr, a_ctr;
      logic pred, alt_pred, move_alt, h0;
      logic [3:0] hl;
      logic [PERIOD_W-1:0] p, nxt;
      logic [WFOLD_W-1:0] nw;
      logic [NFOLD_W-1:0] nn;
      pcmix = pc[9:0] ^ pc[19:10];
      cur_base = pc[11:0];
      cur_idx[0] = pcmix ^ hist_lo[9:0];
      for (b = 1; b < NUM_BANKS; b++) cur_idx[b] = pcmix ^ idx_fold[b-1];
      pv = 0;
      al = 0;
      for (b = 0; b < NUM_BANKS; b++) begin
         tg[b] = pc[7:0] ^ wide_fold[b] ^ {narrow_fold[b], 1'b0};
         if (bank_tag[b][cur_idx[b]] == tg[b]) begin
            al = pv;
            pv = b + 1;
         end
      end
      p_ctr = ctr_get(pv);
      a_ctr = ctr_get(al);
      pred = ~p_ctr[CTR_BITS-1];
      alt_pred = ~a_ctr[CTR_BITS-1];
      res.prediction = pred;
      res.provider_bank = pv[2:0];
      if (op != OP_TRAIN) return;

      move_alt = (pv != 0) && (bank_use[pv-1][cur_idx[pv-1]] == 0);
      if (taken) begin
         if (p_ctr < CTR_MAX) begin
            ctr_set(pv, p_ctr + 3'sd1);
            if (move_alt && a_ctr < CTR_MAX) ctr_set(al, a_ctr + 3'sd1);
         end
      end else begin
         if (p_ctr > CTR_MIN) begin
            ctr_set(pv, p_ctr - 3'sd1);
            if (move_alt && a_ctr > CTR_MIN) ctr_set(al, a_ctr - 3'sd1);
         end
      end

      // allocate in a longer-history bank on a miss
      if (pred != taken && pv < NUM_BANKS) begin
         first = -1;
         second = -1;
         for (b = pv; b < NUM_BANKS && second < 0; b++) begin
            if (bank_use[b][cur_idx[b]] == 0) begin
               if (first < 0) first = b;
               else second = b;
            end
         end
         if (first < 0) begin
            for (b = pv; b < NUM_BANKS; b++)
               if (bank_use[b][cur_idx[b]] > 0) bank_use[b][cur_idx[b]]--;
         end else begin
            pk = (second >= 0 && pick >= 2) ? second : first;
            bank_tag[pk][cur_idx[pk]] = tg[pk];
            bank_ctr[pk][cur_idx[pk]] = taken ? CTR_WEAK_TAKE : CTR_WEAK_NOT;
            bank_use[pk][cur_idx[pk]] = '0;
         end
      end

      if (pv != 0 && alt_pred != pred) begin
         if (pred == taken) begin
            if (bank_use[pv-1][cur_idx[pv-1]] < USE_MAX) bank_use[pv-1][cur_idx[pv-1]]++;
         end else begin
            if (bank_use[pv-1][cur_idx[pv-1]] > 0) bank_use[pv-1][cur_idx[pv-1]]--;
         end
      end

      p = aging_period;
      if (p == 0) p = 1;
      if (p > PERIOD_CAP) p = PERIOD_CAP;
      nxt = {1'b0, train_cnt} + 25'd1;
      if ({1'b0, train_cnt} == p - 25'd1) begin
         for (b = 0; b < NUM_BANKS; b++)
            for (i = 0; i < 1024; i++)
               bank_use[b][i] = bank_use[b][i] & (clear_high ? 2'b01 : 2'b10);
         clear_high = ~clear_high;
         agings_seen++;
      end
      if (nxt >= p) nxt = '0;
      train_cnt = nxt[COUNT_W-1:0];

      hist_hi = {hist_hi[HIST_HI_W-2:0], hist_lo[HIST_LO_W-1]};
      hist_lo = {hist_lo[HIST_LO_W-2:0], taken};
      h0 = hist_lo[0];
      hl = {hist_hi[16], hist_lo[40], hist_lo[20], hist_lo[10]};
      for (b = 0; b < 3; b++)
         idx_fold[b] = {idx_fold[b][8:0], h0 ^ hl[b+1] ^ idx_fold[b][9]};
      for (b = 0; b < NUM_BANKS; b++) begin
         nw = {wide_fold[b][6:0], h0 ^ wide_fold[b][7]};
         nn = {narrow_fold[b][5:0], h0 ^ narrow_fold[b][6]};
         nw[4] = hl[b] ^ wide_fold[b][3];
         nn[4] = hl[b] ^ narrow_fold[b][3];
         wide_fold[b] = nw;
         narrow_fold[b] = nn;
      end
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic send_item(input logic op, input logic [31:0] pc, input logic taken,
                            input logic [1:0] pick);
      lookup_type res;
      int gap;
      req_op = op;
      req_pc = pc;
      req_outcome = taken;
      req_random_pick = pick;
      start = 1'b1;
      do @(posedge clock); while (busy);
      tage_step(op, pc, taken, pick, res);
      pending_lookups = {pending_lookups, res};
      items_sent++;
      if (op == OP_TRAIN) trains_sent++;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic quiesce();
      start = 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_W-1:0] value);
      quiesce();
      csr_valid = 1'b1;
      csr_aging_period = value;
      do @(posedge clock); while (!csr_ready);
      aging_period = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_item(input int noise_pct);
      int k;
      logic taken;
      if ($urandom_range(0, 99) < noise_pct) begin
         send_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)));
      end else begin
         // pool branches whose direction follows recent outcomes
         k = $urandom_range(0, POOL_SIZE - 1);
         taken = outcome_hist[k % 8] ^ k[0];
         if ($urandom_range(0, 9) == 0) taken = ~taken;
         outcome_hist = {outcome_hist[6:0], taken};
         send_item(($urandom_range(0, 6) == 0) ? OP_PREDICT : OP_TRAIN, pc_pool[k], taken,
                   2'($urandom_range(0, 3)));
      end
   endtask

   always @(posedge clock) begin
      lookup_type exp_res;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("status: fail");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            $display("%0t unexpected transfer: prediction %0b bank %0d", $time,
                     rsp_prediction, rsp_provider_bank);
            errors++;
         end else begin
            exp_res = pending_lookups.pop_front();
            if (rsp_prediction !== exp_res.prediction) begin
               $display("%0t prediction mismatch: expected %0b actual %0b", $time,
                        exp_res.prediction, rsp_prediction);
               errors++;
            end
            if (rsp_provider_bank !== exp_res.provider_bank) begin
               $display("%0t provider_bank mismatch: expected %0d actual %0d", $time,
                        exp_res.provider_bank, rsp_provider_bank);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_item(OP_PREDICT, 32'h0000_0000, 1'b0, 2'd0);
      send_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 2'd3);
      send_item(OP_TRAIN, 32'h0000_0000, 1'b0, 2'd0);
      send_item(OP_TRAIN, 32'hFFFF_FFFF, 1'b1, 2'd1);
      send_item(OP_TRAIN, 32'hFFFF_FFFF, 1'b0, 2'd2);
      send_item(OP_TRAIN, 32'h8000_0001, 1'b1, 2'd3);
      send_item(OP_PREDICT, 32'h8000_0001, 1'b0, 2'd0);
   endtask

   // repeated misses on one branch walk allocation up through the banks
   task automatic test_alloc_chain();
      int i;
      for (i = 0; i < 14; i++)
         send_item(OP_TRAIN, 32'h1234_5678, i[0], (i % 3 == 0) ? 2'd2 : 2'd3);
      send_item(OP_PREDICT, 32'h1234_5678, 1'b0, 2'd0);
   endtask

   task automatic test_fast_aging();
      int i;
      write_period(25'd1);
      for (i = 0; i < 12; i++) random_item(10);
      write_period(25'd0);
      for (i = 0; i < 8; i++) random_item(10);
      write_period(25'd3);
      for (i = 0; i < 40; i++) random_item(10);
   endtask

   // count already past a newly lowered period restarts without aging
   task automatic test_lowered_period();
      int i;
      write_period(PERIOD_RESET);
      for (i = 0; i < 20; i++) random_item(0);
      write_period(25'd5);
      for (i = 0; i < 12; i++) random_item(0);
   endtask

   task automatic test_period_extremes();
      int i;
      write_period(PERIOD_CAP);
      for (i = 0; i < 10; i++) random_item(20);
      write_period(25'h1FF_FFFF);
      for (i = 0; i < 10; i++) random_item(20);
   endtask

   task automatic test_random();
      int i;
      write_period(25'd64);
      for (i = 0; i < 1000; i++) random_item(20);
      write_period(PERIOD_RESET);
      for (i = 0; i < 150; i++) random_item(20);
   endtask

   initial begin
      int b, i;
      for (i = 0; i < 4096; i++) base_ctr[i] = '0;
      for (b = 0; b < NUM_BANKS; b++) begin
         for (i = 0; i < 1024; i++) begin
            bank_ctr[b][i] = '0;
            bank_tag[b][i] = '0;
            bank_use[b][i] = '0;
         end
         wide_fold[b] = '0;
         narrow_fold[b] = '0;
      end
      for (b = 0; b < 3; b++) idx_fold[b] = '0;
      hist_lo = '0;
      hist_hi = '0;
      train_cnt = '0;
      clear_high = 1'b1;
      aging_period = PERIOD_RESET;
      for (i = 0; i < POOL_SIZE; i++) pc_pool[i] = $urandom;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_alloc_chain();
      test_fast_aging();
      test_lowered_period();
      test_period_extremes();
      test_random();
      quiesce();

      if (pending_lookups.size() != 0) begin
         $display("%0t %0d expected transfers never arrived", $time, pending_lookups.size());
         errors++;
      end
      $display("run: %0d items (%0d train), %0d aging sweeps, eight aging period settings",
               items_sent, trains_sent, agings_seen);
      $display("run: %0d mismatches", errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/tbp_pkg.sv
design/tbp_ram.sv
design/tbp_hist.sv
design/tbp_update.sv
design/tage_branch_predictor_top.sv
verif/tb_tage_branch_predictor_top.sv
